// ----- rtl/lwgf_pkg.sv -----
package lwgf_pkg;

    localparam int RANGE_W             = 16;
    localparam int CENTRE_W            = 13;
    localparam int APB_DATA_W          = 32;
    localparam int APB_ADDR_W          = 3;
    localparam int DEFAULT_MAX_SAMPLES = 4096;
    localparam int QUEUE_DEPTH         = 4;

    localparam logic [RANGE_W-1:0]  THRESHOLD_RESET = 16'd800;
    localparam logic [CENTRE_W-1:0] CENTRE_MAX      = 13'd8191;

    // register index as decoded from paddr bit 2
    localparam logic REG_THRESHOLD = 1'b0;

    // one classified sample handed from front to back
    typedef struct packed {
        logic has_bit;   // sample was not the seeding one
        logic free_bit;
        logic last;
    } lwgf_entry_t;

endpackage

// ----- rtl/lwgf_front.sv -----
module lwgf_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic [lwgf_pkg::RANGE_W-1:0]  range_mm,
    input  logic                          last_sample,
    input  logic [lwgf_pkg::RANGE_W-1:0]  threshold,
    input  logic                          queue_full,
    output logic                          push,
    output lwgf_pkg::lwgf_entry_t         entry
);
    import lwgf_pkg::*;

    logic [RANGE_W-1:0] previous_range_reg;
    logic [RANGE_W-1:0] previous_range_next;
    logic               seeded_reg;
    logic               seeded_next;
    logic [RANGE_W-1:0] tested;

    assign sample_stall = queue_full;
    assign push         = sample_valid && !queue_full;

    // no return: test the previous raw range instead
    assign tested = (range_mm == '0) ? previous_range_reg : range_mm;

    always_comb
    begin
        entry.has_bit  = seeded_reg;
        entry.free_bit = tested > threshold;
        entry.last     = last_sample;
    end

    always_comb
    begin
        previous_range_next = previous_range_reg;
        seeded_next         = seeded_reg;
        if (push)
        begin
            if (last_sample)
            begin
                previous_range_next = '0;
                seeded_next         = 1'b0;
            end
            else
            begin
                previous_range_next = range_mm;
                seeded_next         = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_range_reg <= '0;
            seeded_reg         <= 1'b0;
        end
        else
        begin
            previous_range_reg <= previous_range_next;
            seeded_reg         <= seeded_next;
        end
    end

endmodule

// ----- rtl/lwgf_queue.sv -----
module lwgf_queue #(
    parameter int DEPTH = lwgf_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lwgf_pkg::lwgf_entry_t push_entry,
    input  logic                  pop,
    output lwgf_pkg::lwgf_entry_t head,
    output logic                  empty,
    output logic                  full
);
    import lwgf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lwgf_entry_t        slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign head  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/lwgf_back.sv -----
module lwgf_back #(
    parameter int MAX_SAMPLES = lwgf_pkg::DEFAULT_MAX_SAMPLES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lwgf_pkg::lwgf_entry_t          head,
    input  logic                           empty,
    output logic                           pop,
    output logic                           gap_valid,
    input  logic                           gap_stall,
    output logic [lwgf_pkg::CENTRE_W-1:0]  gap_centre_half,
    output logic                           gap_found
);
    import lwgf_pkg::*;

    localparam int IDX_W = $clog2(MAX_SAMPLES);
    localparam int CW    = (IDX_W + 2 > CENTRE_W + 1) ? IDX_W + 2 : CENTRE_W + 1;
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_SAMPLES - 1);

    logic             prev_bit_reg,   prev_bit_next;
    logic             have_prev_reg,  have_prev_next;
    logic [IDX_W-1:0] bit_index_reg,  bit_index_next;
    logic [IDX_W-1:0] run_start_reg,  run_start_next;
    logic [IDX_W-1:0] run_length_reg, run_length_next;
    logic [IDX_W-1:0] best_length_reg, best_length_next;
    logic [IDX_W-1:0] best_start_reg, best_start_next;
    logic             best_valid_reg, best_valid_next;

    // best run after this word's update, before the end-of-scan clear
    logic [IDX_W-1:0] upd_best_length;
    logic [IDX_W-1:0] upd_best_start;
    logic             upd_best_valid;

    logic                out_valid_reg,  out_valid_next;
    logic [CENTRE_W-1:0] out_centre_reg, out_centre_next;
    logic                out_found_reg,  out_found_next;

    logic [CW-1:0]       centre_wide;
    logic                out_free;

    // output register frees up when empty or taken this cycle
    assign out_free = !out_valid_reg || !gap_stall;
    assign pop      = !empty && (!head.last || out_free);

    assign gap_valid       = out_valid_reg;
    assign gap_centre_half = out_centre_reg;
    assign gap_found       = out_found_reg;

    always_comb
    begin
        prev_bit_next    = prev_bit_reg;
        have_prev_next   = have_prev_reg;
        bit_index_next   = bit_index_reg;
        run_start_next   = run_start_reg;
        run_length_next  = run_length_reg;
        best_length_next = best_length_reg;
        best_start_next  = best_start_reg;
        best_valid_next  = best_valid_reg;

        if (pop && head.has_bit)
        begin
            if (have_prev_reg)
            begin
                if (prev_bit_reg && !head.free_bit && (run_start_reg != '0))
                begin
                    // run closes, first longest wins
                    if (!best_valid_reg || (run_length_reg > best_length_reg))
                    begin
                        best_length_next = run_length_reg;
                        best_start_next  = run_start_reg;
                        best_valid_next  = 1'b1;
                    end
                    run_start_next  = '0;
                    run_length_next = '0;
                end
                else if (!prev_bit_reg && !head.free_bit)
                begin
                    run_start_next = bit_index_reg;
                end
                else if (prev_bit_reg && head.free_bit)
                begin
                    run_length_next = (run_length_reg < IDX_MAX) ?
                                      run_length_reg + 1'b1 : IDX_MAX;
                end
            end
            prev_bit_next  = head.free_bit;
            have_prev_next = 1'b1;
            bit_index_next = (bit_index_reg < IDX_MAX) ? bit_index_reg + 1'b1 : IDX_MAX;
        end

        upd_best_length = best_length_next;
        upd_best_start  = best_start_next;
        upd_best_valid  = best_valid_next;

        if (pop && head.last)
        begin
            prev_bit_next    = 1'b0;
            have_prev_next   = 1'b0;
            bit_index_next   = '0;
            run_start_next   = '0;
            run_length_next  = '0;
            best_length_next = '0;
            best_start_next  = '0;
            best_valid_next  = 1'b0;
        end
    end

    // centre from the best run including this word's update
    assign centre_wide = (CW'(upd_best_start) << 1) + CW'(upd_best_length);

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_centre_next = out_centre_reg;
        out_found_next  = out_found_reg;
        if (out_free)
        begin
            out_valid_next = 1'b0;
        end
        if (pop && head.last)
        begin
            out_valid_next = 1'b1;
            out_found_next = upd_best_valid;
            if (!upd_best_valid)
            begin
                out_centre_next = '0;
            end
            else if (centre_wide > CW'(CENTRE_MAX))
            begin
                out_centre_next = CENTRE_MAX;
            end
            else
            begin
                out_centre_next = centre_wide[CENTRE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_centre_reg <= out_centre_next;
        out_found_reg  <= out_found_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_bit_reg    <= 1'b0;
            have_prev_reg   <= 1'b0;
            bit_index_reg   <= '0;
            run_start_reg   <= '0;
            run_length_reg  <= '0;
            best_length_reg <= '0;
            best_start_reg  <= '0;
            best_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            prev_bit_reg    <= prev_bit_next;
            have_prev_reg   <= have_prev_next;
            bit_index_reg   <= bit_index_next;
            run_start_reg   <= run_start_next;
            run_length_reg  <= run_length_next;
            best_length_reg <= best_length_next;
            best_start_reg  <= best_start_next;
            best_valid_reg  <= best_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

endmodule

// ----- rtl/lidar_widest_gap_finder.sv -----
// with the queue empty, a last-marked sample word is first written into a queue slot, then
// taken by the back stage, which writes its result word into the result register
// throughput: one sample word per cycle while the queue is not full; the per-word run update in the back stage sets it
// a waiting result word blocks only the back stage; the front keeps filling a 4-entry queue
// reset: rst_n asynchronous active low, clears scan state, queue and output valid
// reset: threshold returns to 800 mm
module lidar_widest_gap_finder #(
    parameter int MAX_SAMPLES = lwgf_pkg::DEFAULT_MAX_SAMPLES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // sample channel
    input  logic                             sample_valid,
    output logic                             sample_stall,
    input  logic [lwgf_pkg::RANGE_W-1:0]     range_mm,
    input  logic                             last_sample,
    // result channel
    output logic                             gap_valid,
    input  logic                             gap_stall,
    output logic [lwgf_pkg::CENTRE_W-1:0]    gap_centre_half,
    output logic                             gap_found,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lwgf_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lwgf_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lwgf_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import lwgf_pkg::*;

    logic [RANGE_W-1:0] threshold_reg;
    logic [RANGE_W-1:0] threshold_next;
    logic               cfg_write;

    logic               queue_push;
    logic               queue_pop;
    logic               queue_empty;
    logic               queue_full;
    lwgf_entry_t        front_entry;
    lwgf_entry_t        queue_head;

    // register file: paddr bit 2 picks the register, only the threshold exists
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        threshold_next = threshold_reg;
        if (cfg_write && (paddr[2] == REG_THRESHOLD))
        begin
            threshold_next = pwdata[RANGE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_THRESHOLD)
        begin
            prdata = APB_DATA_W'(threshold_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
        end
    end

    // front: seeds on the first sample of a scan, turns later samples into free bits
    lwgf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .range_mm     (range_mm),
        .last_sample  (last_sample),
        .threshold    (threshold_reg),
        .queue_full   (queue_full),
        .push         (queue_push),
        .entry        (front_entry)
    );

    // short queue so the front keeps going while a result word waits
    lwgf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (queue_push),
        .push_entry (front_entry),
        .pop        (queue_pop),
        .head       (queue_head),
        .empty      (queue_empty),
        .full       (queue_full)
    );

    // back: pairwise run tracking, best run, result register
    lwgf_back #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (queue_head),
        .empty           (queue_empty),
        .pop             (queue_pop),
        .gap_valid       (gap_valid),
        .gap_stall       (gap_stall),
        .gap_centre_half (gap_centre_half),
        .gap_found       (gap_found)
    );

endmodule

// ----- rtl/lwgf_checker.sv -----
module lwgf_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    input  logic                             sample_stall,
    input  logic [lwgf_pkg::RANGE_W-1:0]     range_mm,
    input  logic                             last_sample,
    input  logic                             gap_valid,
    input  logic                             gap_stall,
    input  logic [lwgf_pkg::CENTRE_W-1:0]    gap_centre_half,
    input  logic                             gap_found,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lwgf_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lwgf_pkg::APB_DATA_W-1:0]  pwdata,
    input  logic [lwgf_pkg::APB_DATA_W-1:0]  prdata,
    input  logic                             pready
);
    import lwgf_pkg::*;

    // stalled sample word holds
    a_sample_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_stall |=> sample_valid && $stable(range_mm) && $stable(last_sample))
        else $error("sample word changed while stalled");

    // stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        gap_valid && gap_stall |=> gap_valid && $stable(gap_centre_half) && $stable(gap_found))
        else $error("result word changed while stalled");

    // no gap means centre reads zero
    a_empty_centre: assert property (@(posedge clk) disable iff (!rst_n)
        gap_valid && !gap_found |-> gap_centre_half == '0)
        else $error("centre nonzero without a gap");

    // a recorded run never starts at index zero, so its centre is at least two
    a_found_centre: assert property (@(posedge clk) disable iff (!rst_n)
        gap_valid && gap_found |-> gap_centre_half >= CENTRE_W'(2))
        else $error("found gap with impossible centre");

    // threshold write reads back on the next cycle
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr[2] == REG_THRESHOLD)
        |=> paddr[2] != REG_THRESHOLD || prdata == APB_DATA_W'($past(pwdata[RANGE_W-1:0])))
        else $error("threshold readback mismatch");

endmodule

bind lidar_widest_gap_finder lwgf_checker u_lwgf_checker (.*);
